// ===== hdl/wgcds_pkg.sv =====
// Shared constants and types for the windowed GC and depth statistics block.
// No dependencies; imported by wgcds_divider and windowed_gc_depth_stats.
package wgcds_pkg;

    // Default sizes for the top-level parameters
    localparam int COUNT_BITS_DEF = 16;
    localparam int DEPTH_BITS_DEF = 32;

    // Fixed field widths
    localparam int WIDTH_BITS = 16;
    localparam int SUM_BITS   = 48;
    localparam int MEAN_BITS  = 40;
    localparam int RATE_BITS  = 15;
    localparam int BIN_BITS   = 7;
    localparam int STAT_BITS  = 2;

    // Shared divider: dividend holds the scaled GC count or depth_sum << 8, divisor holds known bases
    localparam int DIV_BITS = SUM_BITS + 8;
    localparam int DSR_BITS = WIDTH_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    // Window width after reset
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 16'd100;

    // Decision thresholds
    localparam logic [WIDTH_BITS-1:0] MIN_KNOWN  = 16'd30;
    localparam logic [DIV_BITS-1:0]   RATE_SCALE = 56'd25600;
    localparam logic [SUM_BITS-1:0]   SUM_MAX    = '1;
    localparam logic [DIV_BITS-1:0]   MEAN_MAX   = 56'(((64'd1) << MEAN_BITS) - 64'd1);

    // ASCII base codes
    localparam logic [7:0] BASE_G_UC = 8'h47;
    localparam logic [7:0] BASE_C_UC = 8'h43;
    localparam logic [7:0] BASE_N_UC = 8'h4E;
    localparam logic [7:0] BASE_G_LC = 8'h67;
    localparam logic [7:0] BASE_C_LC = 8'h63;
    localparam logic [7:0] BASE_N_LC = 8'h6E;

    // Window status codes
    typedef enum logic [STAT_BITS-1:0] {
        STATUS_ACCEPT = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_ALL_N  = 2'd2
    } win_status_t;

endpackage

// ===== hdl/wgcds_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the rate and mean paths.
// Depends on wgcds_pkg for the dividend and divisor widths.
module wgcds_divider
    import wgcds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [DSR_BITS-1:0] divisor,
    output logic                done,
    output logic [DIV_BITS-1:0] quotient
);

    localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(DIV_BITS - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DSR_BITS-1:0]     rem_reg;
    logic [DSR_BITS-1:0]     rem_next;
    logic [DSR_BITS-1:0]     dsr_reg;
    logic [DIV_BITS-1:0]     nq_reg;
    logic [DSR_BITS:0]       trial;
    logic                    ge;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial    = {rem_reg, nq_reg[DIV_BITS-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? DSR_BITS'(trial - {1'b0, dsr_reg}) : trial[DSR_BITS-1:0];
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift the dividend out and the quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            nq_reg  <= {nq_reg[DIV_BITS-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = nq_reg;

endmodule

// ===== hdl/windowed_gc_depth_stats.sv =====
// Windowed GC content and mean depth statistics over a stream of reference bases.
// A base that does not close a window passes through accept and counter update.
// A closing base then passes prep, the GC rate and the mean division in the bit-serial divider
// before its result loads the output register; a rejected window skips the mean division.
// Reset (rst_n, async low) clears counters, the sequencer and the output valid;
// window_width returns to 100. Depends on wgcds_pkg and wgcds_divider.
module windowed_gc_depth_stats
    import wgcds_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [WIDTH_BITS-1:0] cfg_data,
    // Input item channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            base_code,
    input  logic [31:0]           depth,
    input  logic                  seq_start,
    // Result item channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STAT_BITS-1:0]  status,
    output logic [BIN_BITS-1:0]   gc_bin,
    output logic [RATE_BITS-1:0]  gc_rate_fixed,
    output logic [MEAN_BITS-1:0]  mean_depth_fixed
);

    localparam int CMP_W = (COUNT_BITS > WIDTH_BITS) ? COUNT_BITS : WIDTH_BITS;
    localparam int RJ_W  = CMP_W + 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [31:0] DEPTH_MAX = 32'(((64'd1) << DEPTH_BITS) - 64'd1);
    localparam logic [DIV_BITS-1:0] RATE_MAX = RATE_SCALE;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPDATE = 6'b000010,
        ST_PREP   = 6'b000100,
        ST_GCDIV  = 6'b001000,
        ST_MDIV   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [WIDTH_BITS-1:0]   width_reg;

    // Window counters
    logic [COUNT_BITS-1:0]   pos_reg;
    logic [COUNT_BITS-1:0]   gc_reg;
    logic [COUNT_BITS-1:0]   unk_reg;
    logic [SUM_BITS-1:0]     sum_reg;

    // Captured item
    logic [7:0]              base_reg;
    logic [DEPTH_BITS-1:0]   depth_reg;
    logic                    seq_reg;

    // Snapshot of the closed window
    logic [COUNT_BITS-1:0]   gc_snap_reg;
    logic [COUNT_BITS-1:0]   unk_snap_reg;
    logic [SUM_BITS-1:0]     sum_snap_reg;
    logic [WIDTH_BITS-1:0]   w_snap_reg;
    logic [DSR_BITS-1:0]     known_reg;
    logic                    reject_reg;

    // Result being assembled and output register
    win_status_t             res_status_reg;
    logic [RATE_BITS-1:0]    res_rate_reg;
    logic [MEAN_BITS-1:0]    res_mean_reg;
    logic                    out_valid_reg;
    win_status_t             out_status_reg;
    logic [BIN_BITS-1:0]     out_bin_reg;
    logic [RATE_BITS-1:0]    out_rate_reg;
    logic [MEAN_BITS-1:0]    out_mean_reg;

    // Update-stage signals
    logic [WIDTH_BITS-1:0]   w_eff;
    logic [COUNT_BITS-1:0]   pos_base;
    logic [COUNT_BITS-1:0]   pos_inc;
    logic [COUNT_BITS-1:0]   gc_base;
    logic [COUNT_BITS-1:0]   unk_base;
    logic [SUM_BITS-1:0]     sum_base;
    logic [SUM_BITS:0]       sum_add;
    logic [SUM_BITS-1:0]     sum_sat;
    logic                    is_gc;
    logic                    is_n;
    logic                    close_win;

    // Prep-stage signals
    logic                    all_n;
    logic [DSR_BITS-1:0]     known;
    logic                    reject;
    logic [DIV_BITS-1:0]     gc_scaled;

    // Divider connection
    logic                    div_start;
    logic [DIV_BITS-1:0]     div_dividend;
    logic [DSR_BITS-1:0]     div_divisor;
    logic                    div_done;
    logic [DIV_BITS-1:0]     div_quot;
    logic [DIV_BITS-1:0]     rate_sat;
    logic [DIV_BITS-1:0]     mean_sat;
    logic                    out_load;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Classify the base and apply sequence start to the counters
    always_comb
    begin
        w_eff     = (width_reg == '0) ? WIDTH_BITS'(1) : width_reg;
        is_gc     = (base_reg == BASE_G_UC) || (base_reg == BASE_C_UC) ||
                    (base_reg == BASE_G_LC) || (base_reg == BASE_C_LC);
        is_n      = (base_reg == BASE_N_UC) || (base_reg == BASE_N_LC);
        pos_base  = seq_reg ? '0 : pos_reg;
        gc_base   = seq_reg ? '0 : gc_reg;
        unk_base  = seq_reg ? '0 : unk_reg;
        sum_base  = seq_reg ? '0 : sum_reg;
        pos_inc   = (pos_base == COUNT_MAX) ? COUNT_MAX : pos_base + 1'b1;
        close_win = (CMP_W'(pos_inc) >= CMP_W'(w_eff));
        sum_add   = {1'b0, sum_base} + (SUM_BITS + 1)'(depth_reg);
        sum_sat   = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
    end

    // Classify the closed window, scale the GC count and saturate the quotients
    always_comb
    begin
        all_n     = (CMP_W'(unk_snap_reg) >= CMP_W'(w_snap_reg));
        known     = w_snap_reg - WIDTH_BITS'(unk_snap_reg);
        reject    = ((RJ_W'(unk_snap_reg) << 2) >=
                     (RJ_W'({w_snap_reg, 1'b0}) + RJ_W'(w_snap_reg))) ||
                    (known <= MIN_KNOWN);
        gc_scaled = (DIV_BITS'(gc_snap_reg) << 14) + (DIV_BITS'(gc_snap_reg) << 13) +
                    (DIV_BITS'(gc_snap_reg) << 10);
        rate_sat  = (div_quot > RATE_MAX) ? RATE_MAX : div_quot;
        mean_sat  = (div_quot > MEAN_MAX) ? MEAN_MAX : div_quot;
    end

    // Feed the shared divider: GC rate first, then mean depth
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_BITS'(gc_scaled);
        div_divisor  = known;
        if ((state_reg == ST_PREP) && !all_n)
        begin
            div_start = 1'b1;
        end
        else if ((state_reg == ST_GCDIV) && div_done && !reject_reg)
        begin
            div_start    = 1'b1;
            div_dividend = {sum_snap_reg, 8'd0};
            div_divisor  = known_reg;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = close_win ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                state_next = all_n ? ST_DONE : ST_GCDIV;
            end
            ST_GCDIV:
            begin
                if (div_done)
                begin
                    state_next = reject_reg ? ST_DONE : ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state: sequencer, config register, window counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_RESET;
            pos_reg       <= '0;
            gc_reg        <= '0;
            unk_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            if (state_reg == ST_UPDATE)
            begin
                if (close_win)
                begin
                    // Restart the window with the closing base
                    pos_reg <= COUNT_BITS'(1);
                    gc_reg  <= is_gc ? COUNT_BITS'(1) : '0;
                    unk_reg <= is_n ? COUNT_BITS'(1) : '0;
                    sum_reg <= is_n ? '0 : SUM_BITS'(depth_reg);
                end
                else
                begin
                    pos_reg <= pos_inc;
                    gc_reg  <= (is_gc && (gc_base != COUNT_MAX)) ? gc_base + 1'b1 : gc_base;
                    unk_reg <= (is_n && (unk_base != COUNT_MAX)) ? unk_base + 1'b1 : unk_base;
                    sum_reg <= is_n ? sum_base : sum_sat;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: captured item, window snapshot, results
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            base_reg  <= base_code;
            depth_reg <= (depth > DEPTH_MAX) ? DEPTH_MAX[DEPTH_BITS-1:0]
                                             : depth[DEPTH_BITS-1:0];
            seq_reg   <= seq_start;
        end
        if ((state_reg == ST_UPDATE) && close_win)
        begin
            gc_snap_reg  <= gc_base;
            unk_snap_reg <= unk_base;
            sum_snap_reg <= sum_base;
            w_snap_reg   <= w_eff;
        end
        if (state_reg == ST_PREP)
        begin
            known_reg    <= known;
            reject_reg   <= reject;
            res_rate_reg <= '0;
            res_mean_reg <= '0;
            res_status_reg <= all_n ? STATUS_ALL_N : (reject ? STATUS_REJECT : STATUS_ACCEPT);
        end
        if ((state_reg == ST_GCDIV) && div_done)
        begin
            res_rate_reg <= RATE_BITS'(rate_sat);
        end
        if ((state_reg == ST_MDIV) && div_done)
        begin
            res_mean_reg <= MEAN_BITS'(mean_sat);
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bin_reg    <= res_rate_reg[RATE_BITS-1:8];
            out_rate_reg   <= (res_status_reg == STATUS_ACCEPT) ? res_rate_reg : '0;
            out_mean_reg   <= res_mean_reg;
        end
    end

    // Shared bit-serial divider
    wgcds_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign gc_bin           = out_bin_reg;
    assign gc_rate_fixed    = out_rate_reg;
    assign mean_depth_fixed = out_mean_reg;

endmodule
